@@ rtl/core/nnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared constants, register codes and transfer types of the resize core.
// ----------------------------------------------------------------------------
package nnr_pkg;

	localparam int MAX_SRC_WIDTH  = 128;
	localparam int MAX_SRC_HEIGHT = 128;
	localparam int MAX_CHANNELS   = 4;
	localparam int MAX_DST_DIM    = 1024;
	localparam int PIXEL_BITS     = 16;

	localparam int SX_BITS     = $clog2(MAX_SRC_WIDTH);
	localparam int SY_BITS     = $clog2(MAX_SRC_HEIGHT);
	localparam int CH_BITS     = 2;
	localparam int Q_BITS      = (SX_BITS > SY_BITS) ? SX_BITS : SY_BITS;
	localparam int STORE_BITS  = CH_BITS + SY_BITS + SX_BITS;
	localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;

	localparam int COORD_BITS   = 10;
	localparam int SRC_REG_BITS = 8;
	localparam int DST_REG_BITS = 11;
	localparam int CH_REG_BITS  = 3;
	localparam int NUM_BITS     = COORD_BITS + 1 + SRC_REG_BITS;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam int PADDR_BITS = 5;
	localparam int PDATA_BITS = 32;

	localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [2:0] REG_CHANNELS   = 3'd4;

	localparam logic [SRC_REG_BITS-1:0] SRC_WIDTH_MAX  = SRC_REG_BITS'(MAX_SRC_WIDTH);
	localparam logic [SRC_REG_BITS-1:0] SRC_HEIGHT_MAX = SRC_REG_BITS'(MAX_SRC_HEIGHT);
	localparam logic [DST_REG_BITS-1:0] DST_DIM_MAX    = DST_REG_BITS'(MAX_DST_DIM);
	localparam logic [CH_REG_BITS-1:0]  CHANNELS_MAX   = CH_REG_BITS'(MAX_CHANNELS);

	localparam logic [SRC_REG_BITS-1:0] SRC_WIDTH_RST  = 8'd128;
	localparam logic [SRC_REG_BITS-1:0] SRC_HEIGHT_RST = 8'd128;
	localparam logic [DST_REG_BITS-1:0] DST_WIDTH_RST  = 11'd128;
	localparam logic [DST_REG_BITS-1:0] DST_HEIGHT_RST = 11'd128;
	localparam logic [CH_REG_BITS-1:0]  CHANNELS_RST   = 3'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_FETCH,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic [SRC_REG_BITS-1:0] src_width;
		logic [SRC_REG_BITS-1:0] src_height;
		logic [DST_REG_BITS-1:0] dst_width;
		logic [DST_REG_BITS-1:0] dst_height;
		logic [CH_REG_BITS-1:0]  channels;
	} cfg_t;

	typedef struct packed {
		op_t                     op;
		logic [CH_BITS-1:0]      ch;
		logic [PIXEL_BITS-1:0]   pix;
		logic [NUM_BITS-1:0]     rem_x;
		logic [NUM_BITS-1:0]     rem_y;
		logic [DST_REG_BITS-1:0] den_x;
		logic [DST_REG_BITS-1:0] den_y;
		logic [Q_BITS-1:0]       q_x;
		logic [Q_BITS-1:0]       q_y;
	} entry_t;

endpackage

@@ rtl/core/nnr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_front
// Classifies each accepted item as load, fetch or bad request, drops loads
// outside the source frame and forms the scaled coordinates for the divider.
// ----------------------------------------------------------------------------
module nnr_front (
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            command,
	input  logic [nnr_pkg::COORD_BITS-1:0]  col,
	input  logic [nnr_pkg::COORD_BITS-1:0]  row,
	input  logic [nnr_pkg::CH_BITS-1:0]     channel,
	input  logic [nnr_pkg::PIXEL_BITS-1:0]  pixel_in,
	input  nnr_pkg::cfg_t                   cfg,
	output logic                            push,
	output nnr_pkg::entry_t                 entry
);
	import nnr_pkg::*;

	logic [SRC_REG_BITS-1:0] sw, sh;
	logic [DST_REG_BITS-1:0] dw, dh;
	logic [CH_REG_BITS-1:0]  nc;
	logic                    load_ok, fetch_bad;
	logic [COORD_BITS:0]     odd_x, odd_y;

	always_comb begin
		sw = (cfg.src_width > SRC_WIDTH_MAX) ? SRC_WIDTH_MAX : cfg.src_width;
		sh = (cfg.src_height > SRC_HEIGHT_MAX) ? SRC_HEIGHT_MAX : cfg.src_height;
		dw = (cfg.dst_width > DST_DIM_MAX) ? DST_DIM_MAX : cfg.dst_width;
		dh = (cfg.dst_height > DST_DIM_MAX) ? DST_DIM_MAX : cfg.dst_height;
		nc = (cfg.channels > CHANNELS_MAX) ? CHANNELS_MAX : cfg.channels;
	end

	assign load_ok = (COORD_BITS'(sw) > col) && (COORD_BITS'(sh) > row)
		&& (nc > CH_REG_BITS'(channel));
	assign fetch_bad = (DST_REG_BITS'(col) >= dw) || (DST_REG_BITS'(row) >= dh)
		|| (CH_REG_BITS'(channel) >= nc) || (sw == '0) || (sh == '0);

	assign odd_x = {col, 1'b1};
	assign odd_y = {row, 1'b1};

	always_comb begin
		entry       = '0;
		entry.ch    = channel;
		entry.pix   = pixel_in;
		entry.den_x = dw;
		entry.den_y = dh;
		if (command == CMD_LOAD) begin
			entry.op  = OP_LOAD;
			entry.q_x = col[Q_BITS-1:0];
			entry.q_y = row[Q_BITS-1:0];
		end else if (fetch_bad) begin
			entry.op = OP_BAD;
		end else begin
			entry.op    = OP_FETCH;
			entry.rem_x = NUM_BITS'(odd_x) * NUM_BITS'(sw);
			entry.rem_y = NUM_BITS'(odd_y) * NUM_BITS'(sh);
		end
	end

	// out-of-frame loads are taken and dropped here
	assign push = in_valid && in_ready && ((command == CMD_FETCH) || load_ok);

endmodule

@@ rtl/core/nnr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_queue
// Short register queue between the classifier and the execution pipeline.
// ----------------------------------------------------------------------------
module nnr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nnr_pkg::entry_t push_entry,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output nnr_pkg::entry_t head
);
	import nnr_pkg::*;

	entry_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign not_full  = (count_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a transfer");

endmodule

@@ rtl/core/nnr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_back
// Execution pipeline: one quotient bit per stage for both coordinates, then
// the frame store write, or the frame store read into the output register.
// ----------------------------------------------------------------------------
module nnr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  nnr_pkg::entry_t                q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nnr_pkg::PIXEL_BITS-1:0] pixel_out,
	output logic                           bad_request
);
	import nnr_pkg::*;

	entry_t                  div_s [Q_BITS];
	logic [Q_BITS-1:0]       vld_s;
	logic                    adv;
	entry_t                  last;
	logic [STORE_BITS-1:0]   addr;
	logic [PIXEL_BITS-1:0]   frame_mem [STORE_DEPTH];
	logic [PIXEL_BITS-1:0]   rdata_q;
	logic                    out_valid_q;
	logic                    bad_q;

	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_not_empty;

	for (genvar k = 0; k < Q_BITS; k++) begin : g_div
		localparam int B = Q_BITS - 1 - k;
		entry_t              cur, nxt;
		logic                cur_vld;
		logic [NUM_BITS-1:0] step_x, step_y;

		if (k == 0) begin : g_first
			assign cur     = q_head;
			assign cur_vld = q_pop;
		end else begin : g_next
			assign cur     = div_s[k-1];
			assign cur_vld = vld_s[k-1];
		end

		assign step_x = NUM_BITS'(cur.den_x) << (B + 1);
		assign step_y = NUM_BITS'(cur.den_y) << (B + 1);

		always_comb begin
			nxt = cur;
			if (cur.op == OP_FETCH) begin
				if (cur.rem_x >= step_x) begin
					nxt.rem_x  = cur.rem_x - step_x;
					nxt.q_x[B] = 1'b1;
				end
				if (cur.rem_y >= step_y) begin
					nxt.rem_y  = cur.rem_y - step_y;
					nxt.q_y[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= cur_vld;
			end
		end
	end

	assign last = div_s[Q_BITS-1];
	assign addr = {last.ch, last.q_y[SY_BITS-1:0], last.q_x[SX_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (adv && vld_s[Q_BITS-1]) begin
			if (last.op == OP_LOAD) begin
				frame_mem[addr] <= last.pix;
			end
			if (last.op == OP_FETCH) begin
				rdata_q <= frame_mem[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_q <= (last.op == OP_BAD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[Q_BITS-1] && (last.op != OP_LOAD);
		end
	end

	assign out_valid   = out_valid_q;
	assign bad_request = bad_q;
	assign pixel_out   = bad_q ? '0 : rdata_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during output stall");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s[Q_BITS-1] && (last.op == OP_LOAD)) |=> !out_valid_q)
		else $error("load produced a transfer");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> vld_s[0])
		else $error("queue entry lost at pipeline entry");

endmodule

@@ rtl/core/nearest_neighbor_resize_core.sv @@
`timescale 1ns / 1ps
// path: a fetch result passes the queue slot, one divider stage per source
// coordinate bit and the frame store read register before it is presented
// throughput: one item per cycle, loads and fetches alike, when not stalled
// reset: control and configuration registers take their reset values at once;
// the frame store is not cleared and holds no defined data until loaded
// ----------------------------------------------------------------------------
// nearest_neighbor_resize_core
// Center-aligned nearest neighbor image resize with a local source frame store.
// ----------------------------------------------------------------------------
module nearest_neighbor_resize_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nnr_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [nnr_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [nnr_pkg::PDATA_BITS-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [nnr_pkg::COORD_BITS-1:0]  col,
	input  logic [nnr_pkg::COORD_BITS-1:0]  row,
	input  logic [nnr_pkg::CH_BITS-1:0]     channel,
	input  logic [nnr_pkg::PIXEL_BITS-1:0]  pixel_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nnr_pkg::PIXEL_BITS-1:0]  pixel_out,
	output logic                            bad_request
);
	import nnr_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       push, q_pop, q_not_full, q_not_empty;
	entry_t     push_entry, q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= SRC_WIDTH_RST;
			cfg_q.src_height <= SRC_HEIGHT_RST;
			cfg_q.dst_width  <= DST_WIDTH_RST;
			cfg_q.dst_height <= DST_HEIGHT_RST;
			cfg_q.channels   <= CHANNELS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SRC_WIDTH:  cfg_q.src_width  <= pwdata[SRC_REG_BITS-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= pwdata[SRC_REG_BITS-1:0];
				REG_DST_WIDTH:  cfg_q.dst_width  <= pwdata[DST_REG_BITS-1:0];
				REG_DST_HEIGHT: cfg_q.dst_height <= pwdata[DST_REG_BITS-1:0];
				REG_CHANNELS:   cfg_q.channels   <= pwdata[CH_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SRC_WIDTH:  prdata = PDATA_BITS'(cfg_q.src_width);
			REG_SRC_HEIGHT: prdata = PDATA_BITS'(cfg_q.src_height);
			REG_DST_WIDTH:  prdata = PDATA_BITS'(cfg_q.dst_width);
			REG_DST_HEIGHT: prdata = PDATA_BITS'(cfg_q.dst_height);
			REG_CHANNELS:   prdata = PDATA_BITS'(cfg_q.channels);
			default:        prdata = '0;
		endcase
	end

	assign in_ready = q_not_full;

	nnr_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.col      (col),
		.row      (row),
		.channel  (channel),
		.pixel_in (pixel_in),
		.cfg      (cfg_q),
		.push     (push),
		.entry    (push_entry)
	);

	nnr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_not_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	nnr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.bad_request (bad_request)
	);

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest neighbor resize core. Loads and fetches
// go in through a randomly paced driver and results come out through a
// randomly stalled monitor. An in-bench predictor mirrors the frame store and
// the register file and checks every fetch result in order. The run moves
// through several frame settings, including zero and oversized registers.
// ----------------------------------------------------------------------------
module tb;
	import nnr_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [CH_BITS-1:0]    ch;
		logic [PIXEL_BITS-1:0] pix;
	} pixel_req_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pix;
		logic                  bad;
	} pixel_resp_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [PADDR_BITS-1:0] paddr       = '0;
	logic [PDATA_BITS-1:0] pwdata      = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  command     = CMD_LOAD;
	logic [COORD_BITS-1:0] col         = '0;
	logic [COORD_BITS-1:0] row         = '0;
	logic [CH_BITS-1:0]    channel     = '0;
	logic [PIXEL_BITS-1:0] pixel_in    = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  bad_request;

	cfg_t cfg_shadow = {SRC_WIDTH_RST, SRC_HEIGHT_RST, DST_WIDTH_RST, DST_HEIGHT_RST,
		CHANNELS_RST};

	logic [PIXEL_BITS-1:0] pix_mirror [STORE_DEPTH];
	bit                    loaded [STORE_DEPTH];
	pixel_req_t            pending_reqs [$];
	pixel_resp_t           expected_pixels [$];

	int errors      = 0;
	int gap_cnt     = 0;
	int stall_cnt   = 0;
	int idle_cycles = 0;
	bit steady      = 1'b0;
	bit in_xfer     = 1'b0;

	always #2 clk = ~clk;

	nearest_neighbor_resize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.col(col),
		.row(row),
		.channel(channel),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.bad_request(bad_request)
	);

	function automatic int sat_dim(int v, int m);
		return (v > m) ? m : v;
	endfunction

	function automatic void eff_dims(output int sw, output int sh, output int dw,
		output int dh, output int nc);
		sw = sat_dim(cfg_shadow.src_width, MAX_SRC_WIDTH);
		sh = sat_dim(cfg_shadow.src_height, MAX_SRC_HEIGHT);
		dw = sat_dim(cfg_shadow.dst_width, MAX_DST_DIM);
		dh = sat_dim(cfg_shadow.dst_height, MAX_DST_DIM);
		nc = sat_dim(cfg_shadow.channels, MAX_CHANNELS);
	endfunction

	// center-aligned mapping, floor((2d+1)*s / 2n)
	function automatic int map_axis(int d, int s, int n);
		int q;
		q = ((2 * d + 1) * s) / (2 * n);
		return (q >= s) ? s - 1 : q;
	endfunction

	function automatic int store_index(int ch, int r, int c);
		return (ch * MAX_SRC_HEIGHT + r) * MAX_SRC_WIDTH + c;
	endfunction

	function automatic bit load_in_range(int c, int r, int ch);
		int sw, sh, dw, dh, nc;
		eff_dims(sw, sh, dw, dh, nc);
		return c < sw && r < sh && ch < nc;
	endfunction

	function automatic bit fetch_in_range(int c, int r, int ch);
		int sw, sh, dw, dh, nc;
		eff_dims(sw, sh, dw, dh, nc);
		return c < dw && r < dh && ch < nc && sw != 0 && sh != 0;
	endfunction

	function automatic int fetch_source(int c, int r, int ch);
		int sw, sh, dw, dh, nc;
		eff_dims(sw, sh, dw, dh, nc);
		return store_index(ch, map_axis(r, sh, dh), map_axis(c, sw, dw));
	endfunction

	task automatic predict_resize(pixel_req_t q);
		pixel_resp_t r;
		if (q.cmd == CMD_LOAD) begin
			if (load_in_range(q.col, q.row, q.ch))
				pix_mirror[store_index(q.ch, q.row, q.col)] = q.pix;
		end else begin
			if (fetch_in_range(q.col, q.row, q.ch)) begin
				r.pix = pix_mirror[fetch_source(q.col, q.row, q.ch)];
				r.bad = 1'b0;
			end else begin
				r.pix = '0;
				r.bad = 1'b1;
			end
			expected_pixels.push_back(r);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
	endtask

	task automatic push_load(int c, int r, int ch, int pix);
		pixel_req_t q;
		q.cmd = CMD_LOAD;
		q.col = c;
		q.row = r;
		q.ch  = ch;
		q.pix = pix;
		if (load_in_range(c, r, ch))
			loaded[store_index(ch, r, c)] = 1'b1;
		pending_reqs.push_back(q);
	endtask

	// a good fetch of a never loaded source pixel gets that pixel loaded first
	task automatic push_fetch(int c, int r, int ch);
		pixel_req_t q;
		int sw, sh, dw, dh, nc;
		eff_dims(sw, sh, dw, dh, nc);
		if (fetch_in_range(c, r, ch) && !loaded[fetch_source(c, r, ch)])
			push_load(map_axis(c, sw, dw), map_axis(r, sh, dh), ch, $urandom_range(0, 65535));
		q.cmd = CMD_FETCH;
		q.col = c;
		q.row = r;
		q.ch  = ch;
		q.pix = $urandom_range(0, 65535);
		pending_reqs.push_back(q);
	endtask

	// n counts every queued transfer, the preceding loads included
	task automatic random_items(int n);
		int sw, sh, dw, dh, nc, pick, base;
		eff_dims(sw, sh, dw, dh, nc);
		base = pending_reqs.size();
		while (pending_reqs.size() < base + n) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 && dw > 0 && dh > 0 && nc > 0)
				push_fetch($urandom_range(0, dw - 1), $urandom_range(0, dh - 1),
					$urandom_range(0, nc - 1));
			else if (pick < 75 && sw > 0 && sh > 0 && nc > 0)
				push_load($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
					$urandom_range(0, nc - 1), $urandom_range(0, 65535));
			else if (pick < 90)
				push_fetch($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 3));
			else
				push_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 3),
					$urandom_range(0, 65535));
		end
	endtask

	task automatic write_reg(logic [2:0] idx, int val);
		logic [PDATA_BITS-1:0] mask;
		logic [PDATA_BITS-1:0] data;
		case (idx)
			REG_SRC_WIDTH, REG_SRC_HEIGHT: mask = (1 << SRC_REG_BITS) - 1;
			REG_DST_WIDTH, REG_DST_HEIGHT: mask = (1 << DST_REG_BITS) - 1;
			REG_CHANNELS: mask = (1 << CH_REG_BITS) - 1;
			default: mask = '0;
		endcase
		data = ($urandom & ~mask) | (val & mask);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SRC_WIDTH: cfg_shadow.src_width = data[SRC_REG_BITS-1:0];
			REG_SRC_HEIGHT: cfg_shadow.src_height = data[SRC_REG_BITS-1:0];
			REG_DST_WIDTH: cfg_shadow.dst_width = data[DST_REG_BITS-1:0];
			REG_DST_HEIGHT: cfg_shadow.dst_height = data[DST_REG_BITS-1:0];
			REG_CHANNELS: cfg_shadow.channels = data[CH_REG_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_idle;
		while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int sw, int sh, int dw, int dh, int nc, int n);
		wait_idle();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_CHANNELS, nc);
		write_reg(3'(REG_CHANNELS + $urandom_range(1, 3)), $urandom);
		random_items(n);
	endtask

	// input driver
	always @(negedge clk) begin
		if (in_valid && !in_xfer) begin
		end else if (gap_cnt > 0) begin
			gap_cnt  <= gap_cnt - 1;
			in_valid <= 1'b0;
		end else if (pending_reqs.size() != 0 && arst_n) begin
			if (!steady && $urandom_range(0, 4) == 0) begin
				gap_cnt  <= $urandom_range(1, 10) - 1;
				in_valid <= 1'b0;
			end else begin
				command  <= pending_reqs[0].cmd;
				col      <= pending_reqs[0].col;
				row      <= pending_reqs[0].row;
				channel  <= pending_reqs[0].ch;
				pixel_in <= pending_reqs[0].pix;
				in_valid <= 1'b1;
				void'(pending_reqs.pop_front());
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result stalls
	always @(negedge clk) begin
		if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_ready <= 1'b0;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			stall_cnt <= $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin : check_results
		pixel_resp_t want;
		in_xfer <= in_valid && in_ready;
		if (in_valid && in_ready)
			predict_resize({command, col, row, channel, pixel_in});
		if (out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transfer", pixel_out, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_out !== want.pix)
					report_mismatch("pixel_out", pixel_out, want.pix);
				if (bad_request !== want.bad)
					report_mismatch("bad_request", bad_request, want.bad);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0 || psel)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: corners, alternating bits, out of range, overwrite
		push_load(0, 0, 0, 16'h0000);
		push_load(127, 127, 2, 16'hFFFF);
		push_load(5, 9, 1, 16'hAAAA);
		push_load(9, 5, 1, 16'h5555);
		push_fetch(0, 0, 0);
		push_fetch(127, 127, 2);
		push_fetch(5, 9, 1);
		push_fetch(9, 5, 1);
		push_load(128, 0, 0, 16'h1234);
		push_load(0, 128, 0, 16'h1234);
		push_load(1, 1, 3, 16'h1234);
		push_load(1023, 1023, 3, 16'hFFFF);
		push_fetch(128, 0, 0);
		push_fetch(0, 128, 0);
		push_fetch(0, 0, 3);
		push_fetch(1023, 1023, 3);
		push_load(2, 2, 0, 16'h0F0F);
		push_fetch(2, 2, 0);
		push_load(2, 2, 0, 16'hF0F0);
		push_fetch(2, 2, 0);
		random_items(150);

		run_phase(1, 1, 1, 1, 1, 100);
		run_phase(MAX_SRC_WIDTH, MAX_SRC_HEIGHT, MAX_DST_DIM, MAX_DST_DIM, MAX_CHANNELS, 300);
		run_phase(1, MAX_SRC_HEIGHT, MAX_DST_DIM, 1, 2, 100);
		run_phase(8, 6, 20, 13, 4, 200);
		run_phase(100, 90, 7, 5, 3, 200);
		// zero registers
		run_phase(0, 5, 10, 10, 2, 50);
		run_phase(5, 0, 10, 10, 4, 50);
		run_phase(5, 5, 0, 10, 2, 50);
		run_phase(5, 5, 10, 0, 2, 50);
		run_phase(5, 5, 10, 10, 0, 50);
		// oversized registers saturate
		run_phase(200, 255, 2047, 1500, 7, 200);
		for (int k = 0; k < 3; k++)
			run_phase($urandom_range(1, MAX_SRC_WIDTH), $urandom_range(1, MAX_SRC_HEIGHT),
				$urandom_range(1, MAX_DST_DIM), $urandom_range(1, MAX_DST_DIM),
				$urandom_range(1, MAX_CHANNELS), 150);
		steady <= 1'b1;
		run_phase($urandom_range(1, MAX_SRC_WIDTH), $urandom_range(1, MAX_SRC_HEIGHT),
			$urandom_range(1, MAX_DST_DIM), $urandom_range(1, MAX_DST_DIM),
			$urandom_range(1, MAX_CHANNELS), 200);
		wait_idle();

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/nnr_pkg.sv
rtl/core/nnr_front.sv
rtl/core/nnr_queue.sv
rtl/core/nnr_back.sv
rtl/core/nearest_neighbor_resize_core.sv
sim/tb.sv
